/* sv/length_prefix_deframer_core_macros.svh */
// assertion macros for the length prefix deframer
// used by the modules that carry concurrent checks; no other dependencies
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lpd_pkg.sv */
// shared types and constants for the length prefix deframer
// no dependencies
package lpd_pkg;

    localparam int MAX_HEAD_BYTES = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 2'd2;

    localparam logic [2:0]  RST_HEAD_BYTES = 3'd4;
    localparam logic        RST_BIG_ENDIAN = 1'b1;
    localparam logic [31:0] RST_MAX_LENGTH = 32'd65535;

    localparam logic OP_DATA     = 1'b0;
    localparam logic OP_LINK_ERR = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_LINK_ERR = 2'd2;

    typedef struct packed {
        logic [2:0]  head_bytes;
        logic        big_endian;
        logic [31:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       msg_last;
        logic [1:0] status;
    } result_t;

endpackage

/* sv/length_prefix_deframer_core.sv */
// top level of the length prefix deframer: config registers, tracker, result register
// depends on lpd_pkg, lpd_cfg, lpd_parse, lpd_out
//
//  channel | dir | handshake         | contents
//  s_      | in  | s_tvalid/s_tready | tdata data_byte, tuser op, tlast chunk_end
//  m_      | out | m_tvalid/m_tready | tdata out_byte, tuser has_byte/status, tlast msg_last
//  cfg_    | in  | cfg_wr_en         | cfg_index register, cfg_wdata value
//
// one beat per cycle while s_tready is high; a beat's result shows on m_ in the cycle after it is taken
// the tracker updates its counters in the cycle of acceptance; a single result register
// decouples the sides, so s_tready is low only while that register holds an untaken result
// header bytes and beats dropped after an error give no output
// synchronous active-low reset clears all state except the result data register and restores register defaults
module length_prefix_deframer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] op
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic [2:0]                      m_tuser,   // [0] has_byte, [2:1] status
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lpd_pkg::*;

    cfg_t     cfg;
    in_beat_t beat;
    result_t  res;
    result_t  m_res;
    logic     res_valid;
    logic     slot_free;
    logic     beat_acc;

    assign beat.op        = s_tuser;
    assign beat.data_byte = s_tdata;
    assign beat.chunk_end = s_tlast;

    assign s_tready = slot_free;
    assign beat_acc = s_tvalid && slot_free;

    lpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lpd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_acc  (beat_acc),
        .beat      (beat),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = m_res.out_byte;
    assign m_tuser = {m_res.status, m_res.has_byte};
    assign m_tlast = m_res.msg_last;

endmodule

/* sv/lpd_cfg.sv */
// configuration register file for the length prefix deframer
// depends on lpd_pkg
module lpd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output lpd_pkg::cfg_t                      cfg
);
    import lpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEAD_BYTES: cfg_next.head_bytes = cfg_wdata[2:0];
                REG_BIG_ENDIAN: cfg_next.big_endian = cfg_wdata[0];
                REG_MAX_LENGTH: cfg_next.max_length = cfg_wdata[31:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_bytes <= RST_HEAD_BYTES;
            cfg_reg.big_endian <= RST_BIG_ENDIAN;
            cfg_reg.max_length <= RST_MAX_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/lpd_parse.sv */
// header/payload tracker: per-beat state update and result decision
// depends on lpd_pkg and length_prefix_deframer_core_macros.svh
`include "length_prefix_deframer_core_macros.svh"

module lpd_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_acc,
    input  lpd_pkg::in_beat_t beat,
    input  lpd_pkg::cfg_t     cfg,
    output logic              res_valid,
    output lpd_pkg::result_t  res
);
    import lpd_pkg::*;

    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        in_payload_reg, in_payload_next;
    logic        error_latched_reg, error_latched_next;
    logic        length_over_reg, length_over_next;

    logic [2:0]  head_eff;
    logic [31:0] accum_new;
    logic        over_new;
    logic [2:0]  count_new;
    logic [31:0] rem_dec;

    assign head_eff = (cfg.head_bytes > 3'(MAX_HEAD_BYTES)) ? 3'(MAX_HEAD_BYTES)
                                                           : cfg.head_bytes;
    assign count_new = header_count_reg + 3'd1;
    assign rem_dec   = (remaining_reg == 32'd0) ? 32'd0 : remaining_reg - 32'd1;

    // header byte folded into the length, either byte order
    always_comb begin
        accum_new = length_accum_reg;
        over_new  = length_over_reg;
        if (cfg.big_endian) begin
            if (length_accum_reg[31:24] != 8'd0) begin
                over_new = 1'b1;
            end
            accum_new = {length_accum_reg[23:0], beat.data_byte};
        end else if (header_count_reg < 3'd4) begin
            accum_new = length_accum_reg
                      | (32'(beat.data_byte) << {header_count_reg[1:0], 3'b000});
        end else if (beat.data_byte != 8'd0) begin
            over_new = 1'b1;
        end
    end

    always_comb begin
        header_count_next  = header_count_reg;
        length_accum_next  = length_accum_reg;
        remaining_next     = remaining_reg;
        in_payload_next    = in_payload_reg;
        error_latched_next = error_latched_reg;
        length_over_next   = length_over_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (beat_acc && !error_latched_reg) begin
            if (beat.op == OP_LINK_ERR) begin
                header_count_next  = 3'd0;
                length_accum_next  = 32'd0;
                remaining_next     = 32'd0;
                in_payload_next    = 1'b0;
                length_over_next   = 1'b0;
                error_latched_next = 1'b1;
                res_valid          = 1'b1;
                res.msg_last       = 1'b1;
                res.status         = STATUS_LINK_ERR;
            end else if (in_payload_reg) begin
                res_valid    = 1'b1;
                res.out_byte = beat.data_byte;
                res.has_byte = 1'b1;
                res.status   = STATUS_OK;
                if (rem_dec == 32'd0) begin
                    header_count_next = 3'd0;
                    length_accum_next = 32'd0;
                    remaining_next    = 32'd0;
                    in_payload_next   = 1'b0;
                    length_over_next  = 1'b0;
                    res.msg_last      = 1'b1;
                end else begin
                    remaining_next = rem_dec;
                end
            end else if (head_eff == 3'd0) begin
                // chunk pass-through
                res_valid    = 1'b1;
                res.out_byte = beat.data_byte;
                res.has_byte = 1'b1;
                res.msg_last = beat.chunk_end;
                res.status   = STATUS_OK;
            end else if (count_new != 3'd0 && count_new < head_eff) begin
                header_count_next = count_new;
                length_accum_next = accum_new;
                length_over_next  = over_new;
            end else begin
                header_count_next = 3'd0;
                length_accum_next = 32'd0;
                length_over_next  = 1'b0;
                if (over_new || accum_new > cfg.max_length) begin
                    remaining_next     = 32'd0;
                    in_payload_next    = 1'b0;
                    error_latched_next = 1'b1;
                    res_valid          = 1'b1;
                    res.msg_last       = 1'b1;
                    res.status         = STATUS_TOO_LONG;
                end else if (accum_new == 32'd0) begin
                    // empty message
                    remaining_next = 32'd0;
                    in_payload_next = 1'b0;
                    res_valid      = 1'b1;
                    res.msg_last   = 1'b1;
                    res.status     = STATUS_OK;
                end else begin
                    remaining_next  = accum_new;
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg  <= 3'd0;
            length_accum_reg  <= 32'd0;
            remaining_reg     <= 32'd0;
            in_payload_reg    <= 1'b0;
            error_latched_reg <= 1'b0;
            length_over_reg   <= 1'b0;
        end else begin
            header_count_reg  <= header_count_next;
            length_accum_reg  <= length_accum_next;
            remaining_reg     <= remaining_next;
            in_payload_reg    <= in_payload_next;
            error_latched_reg <= error_latched_next;
            length_over_reg   <= length_over_next;
        end
    end

    `LPD_ASSERT_NEXT(a_err_sticky, aclk, aresetn, error_latched_reg, error_latched_reg, "error latch cleared without reset")
    `LPD_ASSERT_NOW(a_payload_nonzero, aclk, aresetn, in_payload_reg, remaining_reg != 32'd0, "payload active with zero bytes left")
    `LPD_ASSERT_NOW(a_quiet_after_err, aclk, aresetn, error_latched_reg, !res_valid, "result produced after error")
    `LPD_ASSERT_NEXT(a_err_latches, aclk, aresetn, res_valid && res.status != STATUS_OK, error_latched_reg, "error report did not latch")

endmodule

/* sv/lpd_out.sv */
// result register between the tracker and the master side
// depends on lpd_pkg
module lpd_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  lpd_pkg::result_t res,
    output logic             slot_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lpd_pkg::result_t m_res
);
    import lpd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // slot can be refilled in the same cycle it drains
    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule
